// File: hdl/chrl_pkg.sv
// chrl_pkg: shared types and constants for the hash ring lookup block
// no dependencies; compiled first

package chrl_pkg;

    localparam int OP_W   = 2;
    localparam int POS_W  = 32;
    localparam int NODE_W = 8;
    localparam int ST_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_COMMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

// File: hdl/chrl_ifs.sv
// chrl_req_if / chrl_rsp_if: valid/ready channels for requests and results
// depends on chrl_pkg for field widths

interface chrl_req_if;
    logic                         valid;
    logic                         ready;
    logic [chrl_pkg::OP_W-1:0]    operation;
    logic [chrl_pkg::POS_W-1:0]   position;
    logic [chrl_pkg::NODE_W-1:0]  node_id;

    modport source (output valid, output operation, output position, output node_id,
                    input ready);
    modport sink   (input valid, input operation, input position, input node_id,
                    output ready);
endinterface

interface chrl_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [chrl_pkg::NODE_W-1:0]  found_node;
    logic [chrl_pkg::ST_W-1:0]    status;

    modport source (output valid, output found_node, output status, input ready);
    modport sink   (input valid, input found_node, input status, output ready);
endinterface

// File: hdl/consistent_hash_ring_lookup.sv
// consistent_hash_ring_lookup: top level of the hash ring point store
// depends on chrl_pkg, chrl_ifs, chrl_ctrl, chrl_cells
//
// usage
//   req channel (sink): operation, position, node_id; one transfer per request
//     add inserts a point or overwrites the node at an existing position,
//     remove deletes the point at a position, lookup returns the node at the
//     first position at or above the key, wrapping to the lowest point
//   rsp channel (source): found_node, status; exactly one transfer per request
//     status ok, ring empty on lookup, ring full on add, or absent on remove
//   timing: the cycle of its transfer registers the compare of every cell against
//     the position; the commit state then shifts the cells and loads the result
//     register once the output register is free; rsp.valid rises the cycle after that
//   sequencing: no new request is taken until the previous one has committed, as
//     set by the compare-then-shift sequence over the single cell array
//   stall: a result waits in its output register while rsp.ready is low; the
//     next request is still taken, and holds in its commit cycle until the
//     pending result has been transferred
//   reset: rst_n clears the point count and the channel state; the ring is
//     empty afterward and needs no clearing pass

module consistent_hash_ring_lookup
#(
    parameter int RING_ENTRIES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    chrl_req_if.sink           req,
    chrl_rsp_if.source         rsp
);

    chrl_pkg::cmd_t cmd;

    // sequencing and handshake flags
    chrl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // ordered point cells, compare array and result register
    chrl_cells
    #(
        .RING_ENTRIES (RING_ENTRIES)
    )
    u_cells
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .operation  (req.operation),
        .position   (req.position),
        .node_id    (req.node_id),
        .found_node (rsp.found_node),
        .status     (rsp.status)
    );

endmodule

// File: hdl/chrl_ctrl.sv
// chrl_ctrl: request sequencer and result valid flag
// depends on chrl_pkg

module chrl_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output chrl_pkg::cmd_t   cmd
);

    chrl_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chrl_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chrl_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = chrl_pkg::S_COMMIT;
            end
            chrl_pkg::S_COMMIT:
            begin
                if (slot_free)
                    state_next = chrl_pkg::S_IDLE;
            end
            default: state_next = chrl_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            chrl_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            chrl_pkg::S_COMMIT:
            begin
                cmd.commit = slot_free;
            end
            default: ;
        endcase
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg && state_reg == chrl_pkg::S_IDLE)
        else $error("result not presented after commit");
    a_capture_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == chrl_pkg::S_COMMIT && !in_ready)
        else $error("accepted request not held for commit");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !cmd.commit)
        else $error("pending result overwritten");
`endif

endmodule

// File: hdl/chrl_cells.sv
// chrl_cells: ordered array of ring points with per-cell compare and shift
// depends on chrl_pkg; driven by chrl_ctrl commands

module chrl_cells
#(
    parameter int RING_ENTRIES = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  chrl_pkg::cmd_t                cmd,
    input  logic [chrl_pkg::OP_W-1:0]     operation,
    input  logic [chrl_pkg::POS_W-1:0]    position,
    input  logic [chrl_pkg::NODE_W-1:0]   node_id,
    output logic [chrl_pkg::NODE_W-1:0]   found_node,
    output logic [chrl_pkg::ST_W-1:0]     status
);

    localparam int CW = $clog2(RING_ENTRIES + 1);

    logic [chrl_pkg::POS_W-1:0]  pos_reg  [RING_ENTRIES];
    logic [chrl_pkg::NODE_W-1:0] node_reg [RING_ENTRIES];
    logic [chrl_pkg::POS_W-1:0]  pos_next [RING_ENTRIES];
    logic [chrl_pkg::NODE_W-1:0] node_next[RING_ENTRIES];
    logic [chrl_pkg::POS_W-1:0]  pos_dn   [RING_ENTRIES];
    logic [chrl_pkg::NODE_W-1:0] node_dn  [RING_ENTRIES];
    logic [chrl_pkg::POS_W-1:0]  pos_up   [RING_ENTRIES];
    logic [chrl_pkg::NODE_W-1:0] node_up  [RING_ENTRIES];

    logic [CW-1:0]               count_reg, count_next;
    logic [chrl_pkg::OP_W-1:0]   op_reg;
    logic [chrl_pkg::POS_W-1:0]  key_pos_reg;
    logic [chrl_pkg::NODE_W-1:0] key_node_reg;
    logic [RING_ENTRIES-1:0]     lt_reg, lt_next;
    logic [RING_ENTRIES-1:0]     eq_reg, eq_next;
    logic [RING_ENTRIES-1:0]     cell_vld;
    logic [RING_ENTRIES-1:0]     lt_shift;
    logic [RING_ENTRIES-1:0]     first_vec;
    logic [chrl_pkg::NODE_W-1:0] found_reg, found_next;
    logic [chrl_pkg::ST_W-1:0]   status_reg, status_next;
    logic [chrl_pkg::NODE_W-1:0] lookup_node;
    logic                        hit, full, empty, any_ge;

    // occupied cells sit below the count
    always_comb
    begin
        for (int i = 0; i < RING_ENTRIES; i++)
            cell_vld[i] = CW'(i) < count_reg;
    end

    // per-cell compare against the incoming position
    always_comb
    begin
        for (int i = 0; i < RING_ENTRIES; i++)
        begin
            lt_next[i] = cell_vld[i] && (pos_reg[i] < position);
            eq_next[i] = cell_vld[i] && (pos_reg[i] == position);
        end
    end

    // neighbor taps for insert (from below) and remove (from above)
    always_comb
    begin
        pos_dn[0]  = key_pos_reg;
        node_dn[0] = key_node_reg;
        for (int i = 1; i < RING_ENTRIES; i++)
        begin
            pos_dn[i]  = pos_reg[i-1];
            node_dn[i] = node_reg[i-1];
        end
        for (int i = 0; i < RING_ENTRIES - 1; i++)
        begin
            pos_up[i]  = pos_reg[i+1];
            node_up[i] = node_reg[i+1];
        end
        pos_up[RING_ENTRIES-1]  = pos_reg[RING_ENTRIES-1];
        node_up[RING_ENTRIES-1] = node_reg[RING_ENTRIES-1];
    end

    // first cell at or above the key, and its node
    always_comb
    begin
        lt_shift    = {lt_reg[RING_ENTRIES-2:0], 1'b1};
        first_vec   = cell_vld & ~lt_reg & lt_shift;
        any_ge      = |first_vec;
        hit         = |eq_reg;
        full        = count_reg == CW'(RING_ENTRIES);
        empty       = count_reg == '0;
        lookup_node = '0;
        for (int i = 0; i < RING_ENTRIES; i++)
        begin
            if (first_vec[i])
                lookup_node = lookup_node | node_reg[i];
        end
    end

    // ring update and result
    always_comb
    begin
        pos_next    = pos_reg;
        node_next   = node_reg;
        count_next  = count_reg;
        found_next  = '0;
        status_next = chrl_pkg::ST_OK;
        unique case (op_reg)
            chrl_pkg::OP_ADD:
            begin
                if (hit)
                begin
                    for (int i = 0; i < RING_ENTRIES; i++)
                    begin
                        if (eq_reg[i])
                            node_next[i] = key_node_reg;
                    end
                end
                else if (full)
                    status_next = chrl_pkg::ST_FULL;
                else
                begin
                    // cells at or above the slot move up by one
                    for (int i = 0; i < RING_ENTRIES; i++)
                    begin
                        if (!lt_reg[i])
                        begin
                            pos_next[i]  = lt_shift[i] ? key_pos_reg  : pos_dn[i];
                            node_next[i] = lt_shift[i] ? key_node_reg : node_dn[i];
                        end
                    end
                    count_next = count_reg + CW'(1);
                end
            end
            chrl_pkg::OP_REMOVE:
            begin
                if (!hit)
                    status_next = chrl_pkg::ST_ABSENT;
                else
                begin
                    // cells from the match upward move down by one
                    for (int i = 0; i < RING_ENTRIES; i++)
                    begin
                        if (!lt_reg[i])
                        begin
                            pos_next[i]  = pos_up[i];
                            node_next[i] = node_up[i];
                        end
                    end
                    count_next = count_reg - CW'(1);
                end
            end
            chrl_pkg::OP_LOOKUP:
            begin
                if (empty)
                    status_next = chrl_pkg::ST_EMPTY;
                else
                    found_next = any_ge ? lookup_node : node_reg[0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.commit)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= operation;
            key_pos_reg  <= position;
            key_node_reg <= node_id;
            lt_reg       <= lt_next;
            eq_reg       <= eq_next;
        end
        if (cmd.commit)
        begin
            pos_reg    <= pos_next;
            node_reg   <= node_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    assign found_node = found_reg;
    assign status     = status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(RING_ENTRIES))
        else $error("point count beyond ring size");
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(count_reg))
        else $error("point count changed without commit");
    a_sorted_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.capture) |-> ((lt_reg >> 1) & ~lt_reg) == '0)
        else $error("ring order broken: below-key cells not a prefix");
    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.capture) |-> $onehot0(eq_reg))
        else $error("duplicate position in ring");
`endif

endmodule
